>>> design/ttw_pkg.sv
// Package for the idle-timeout timing wheel: action and result codes,
// controller states, and the command/status structs between control and datapath.
// No dependencies.
`default_nettype none

package ttw_pkg;

	localparam int ACTION_W = 2;
	localparam int ID_W     = 10;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 6;
	localparam int COUNT_W  = 11;

	localparam logic [SLOT_W-1:0]  SLOT_TOP_RST = 6'd15;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 11'd2047;

	typedef enum logic [1:0] {
		ACT_INSERT,
		ACT_TOUCH,
		ACT_REMOVE,
		ACT_TICK
	} act_t;

	typedef enum logic [1:0] {
		RES_DONE,
		RES_DUP,
		RES_ABSENT
	} res_t;

	typedef enum logic [2:0] {
		CTL_CLEAR,
		CTL_IDLE,
		CTL_LOOK,
		CTL_DEC,
		CTL_INC,
		CTL_TICK,
		CTL_HOLD
	} ctl_state_t;

	// count memory read address source
	typedef enum logic [1:0] {
		CA_PREV,
		CA_CUR,
		CA_MAP,
		CA_NEXT
	} cnt_sel_t;

	typedef struct packed {
		logic     clr;      // clearing sweep step
		logic     accept;   // capture request, read id map
		logic     adv;      // tick: advance wheel pointers
		logic     map_wr;
		logic     map_set;  // 1: write valid entry, 0: drop entry
		logic     map_cur;  // slot for a valid entry: current (1) or previous (0)
		logic     cnt_rd;
		cnt_sel_t cnt_sel;
		logic     cnt_dec;
		logic     cnt_inc;
		logic     fin;      // result ready this cycle
		res_t     res;
		logic     tick_res;
		logic     push;     // move held result into output register
	} ttw_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
		logic id_ok;
		logic hit;
		logic in_prev;
		logic in_cur;
	} ttw_sts_t;

endpackage

`default_nettype wire

>>> design/idle_timeout_timing_wheel.sv
// Channel   Signals                                         Dir  Handshake
// cfg       cfg_data[5:0] (slot_top)                        in   cfg_valid / cfg_ready
// request   action[1:0], timer_id[9:0]                      in   in_valid / in_stall
// result    status, expired_valid, expired_slot, expired_count  out  out_valid / out_stall
//
// A request that changes the wheel reads the id map, then writes it and the count memory
// (read, then write); a touch that moves an id updates its old and its current slot count.
// After reset a clearing pass over max(TIMER_IDS, MAX_SLOTS) addresses (1024 by default)
// sweeps both memories; in_stall stays high during it, config writes are taken.
// A finished result waits in the output register; the next request is accepted
// meanwhile, and its result is held until the output register frees up.
// Top level: instantiates ttw_ctrl and ttw_dp; uses ttw_pkg.
`default_nettype none

module idle_timeout_timing_wheel #(
	parameter int TIMER_IDS = 1024,
	parameter int MAX_SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ttw_pkg::SLOT_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ttw_pkg::ACTION_W-1:0]  action,
	input  logic [ttw_pkg::ID_W-1:0]      timer_id,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ttw_pkg::STATUS_W-1:0]  status,
	output logic                          expired_valid,
	output logic [ttw_pkg::SLOT_W-1:0]    expired_slot,
	output logic [ttw_pkg::COUNT_W-1:0]   expired_count
);
	import ttw_pkg::*;

	ttw_cmd_t cmd;
	ttw_sts_t sts;

	assign cfg_ready = 1'b1;

	ttw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	ttw_dp #(
		.TIMER_IDS (TIMER_IDS),
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.timer_id      (timer_id),
		.out_stall     (out_stall),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.status        (status),
		.expired_valid (expired_valid),
		.expired_slot  (expired_slot),
		.expired_count (expired_count)
	);

`ifndef SYNTHESIS
	// an accepted request keeps the next one out in the cycle after it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted back to back");

	// no result is produced in the cycle a request is taken
	a_no_result_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !(cmd.fin || cmd.push))
		else $error("result produced while accepting");

	a_fin_push_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.fin && cmd.push))
		else $error("finish and push together");

	a_cnt_rmw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cnt_dec && cmd.cnt_inc) && !(cmd.clr && (cmd.cnt_dec || cmd.cnt_inc)))
		else $error("conflicting count writes");
`endif

endmodule

`default_nettype wire

>>> design/ttw_ctrl.sv
// Controller of the timing wheel: sequences clear sweep, map lookup,
// count read-modify-write and result hand-off. Uses ttw_pkg.
`default_nettype none

module ttw_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [ttw_pkg::ACTION_W-1:0]  action,
	input  ttw_pkg::ttw_sts_t             sts,
	output logic                          in_stall,
	output ttw_pkg::ttw_cmd_t             cmd
);
	import ttw_pkg::*;

	ctl_state_t state_q, state_nxt;
	act_t       act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q <= act_t'(action);
		end
	end

	assign in_stall = (state_q != CTL_IDLE);

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		cmd.cnt_sel = CA_PREV;
		cmd.res     = RES_DONE;
		unique case (state_q)
			CTL_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_nxt = CTL_IDLE;
				end
			end
			CTL_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (act_t'(action) == ACT_TICK) begin
						cmd.adv     = 1'b1;
						cmd.cnt_rd  = 1'b1;
						cmd.cnt_sel = CA_NEXT;
						state_nxt   = CTL_TICK;
					end else begin
						state_nxt = CTL_LOOK;
					end
				end
			end
			CTL_TICK: begin
				cmd.fin      = 1'b1;
				cmd.tick_res = 1'b1;
			end
			CTL_LOOK: begin
				if (!sts.id_ok) begin
					cmd.fin = 1'b1;
					cmd.res = RES_ABSENT;
				end else begin
					unique case (act_q)
						ACT_INSERT: begin
							if (sts.hit) begin
								cmd.fin = 1'b1;
								cmd.res = RES_DUP;
							end else begin
								cmd.map_wr  = 1'b1;
								cmd.map_set = 1'b1;
								cmd.cnt_rd  = 1'b1;
								cmd.cnt_sel = CA_PREV;
								state_nxt   = CTL_INC;
							end
						end
						ACT_TOUCH: begin
							if (!sts.hit) begin
								cmd.fin = 1'b1;
								cmd.res = RES_ABSENT;
							end else if (sts.in_prev || sts.in_cur) begin
								// nothing moves
								cmd.fin = 1'b1;
							end else begin
								cmd.map_wr  = 1'b1;
								cmd.map_set = 1'b1;
								cmd.map_cur = 1'b1;
								cmd.cnt_rd  = 1'b1;
								cmd.cnt_sel = CA_MAP;
								state_nxt   = CTL_DEC;
							end
						end
						ACT_REMOVE: begin
							if (!sts.hit) begin
								cmd.fin = 1'b1;
								cmd.res = RES_ABSENT;
							end else begin
								cmd.map_wr  = 1'b1;
								cmd.cnt_rd  = 1'b1;
								cmd.cnt_sel = CA_MAP;
								state_nxt   = CTL_DEC;
							end
						end
						default: begin
							cmd.fin = 1'b1;
						end
					endcase
				end
			end
			CTL_DEC: begin
				cmd.cnt_dec = 1'b1;
				if (act_q == ACT_TOUCH) begin
					cmd.cnt_rd  = 1'b1;
					cmd.cnt_sel = CA_CUR;
					state_nxt   = CTL_INC;
				end else begin
					cmd.fin = 1'b1;
				end
			end
			CTL_INC: begin
				cmd.cnt_inc = 1'b1;
				cmd.fin     = 1'b1;
			end
			CTL_HOLD: begin
				if (sts.out_free) begin
					cmd.push  = 1'b1;
					state_nxt = CTL_IDLE;
				end
			end
			default: begin
				state_nxt = CTL_IDLE;
			end
		endcase
		if (cmd.fin) begin
			state_nxt = sts.out_free ? CTL_IDLE : CTL_HOLD;
		end
	end

endmodule

`default_nettype wire

>>> design/ttw_dp.sv
// Datapath of the timing wheel: id map and slot count memories, wheel
// pointers, slot_top register, clear sweep and output register. Uses ttw_pkg.
`default_nettype none

module ttw_dp #(
	parameter int TIMER_IDS = 1024,
	parameter int MAX_SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ttw_pkg::SLOT_W-1:0]    cfg_data,
	input  logic [ttw_pkg::ID_W-1:0]      timer_id,
	input  logic                          out_stall,
	input  ttw_pkg::ttw_cmd_t             cmd,
	output ttw_pkg::ttw_sts_t             sts,
	output logic                          out_valid,
	output logic [ttw_pkg::STATUS_W-1:0]  status,
	output logic                          expired_valid,
	output logic [ttw_pkg::SLOT_W-1:0]    expired_slot,
	output logic [ttw_pkg::COUNT_W-1:0]   expired_count
);
	import ttw_pkg::*;

	localparam int ID_AW    = $clog2(TIMER_IDS);
	localparam int SLOT_AW  = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W    = $clog2(TIMER_IDS + 1);
	localparam int CLR_N    = (TIMER_IDS > MAX_SLOTS) ? TIMER_IDS : MAX_SLOTS;
	localparam int CLR_W    = $clog2(CLR_N);
	localparam int TOP_LIM  = (MAX_SLOTS - 1 > 63) ? 63 : MAX_SLOTS - 1;
	localparam int PREV_RST = (TOP_LIM > 15) ? 15 : TOP_LIM;

	// map entry: valid in the top bit, slot below
	logic [SLOT_AW:0]   map_mem [TIMER_IDS];
	logic [CNT_W-1:0]   cnt_mem [MAX_SLOTS];

	logic [SLOT_W-1:0]  slot_top_q, cur_q, prev_q;
	logic [CLR_W-1:0]   clr_q;
	logic [ID_W-1:0]    id_q;
	logic [SLOT_AW:0]   map_rd_q;
	logic [CNT_W-1:0]   cnt_rd_q;
	logic [SLOT_AW-1:0] cnt_wa_q;

	logic [STATUS_W-1:0] res_st_q;
	logic                res_ev_q;
	logic [SLOT_W-1:0]   res_es_q;
	logic [COUNT_W-1:0]  res_ec_q;

	logic [SLOT_W-1:0]   top_eff, cur_nxt;
	logic [SLOT_AW-1:0]  cnt_ra, map_slot;
	logic [ID_AW-1:0]    id_idx, clr_id;
	logic [SLOT_AW-1:0]  clr_slot;
	logic                clr_map_en, clr_cnt_en;
	logic                map_we, cnt_we;
	logic [ID_AW-1:0]    map_wa;
	logic [SLOT_AW:0]    map_wd;
	logic [SLOT_AW-1:0]  cnt_wa;
	logic [CNT_W-1:0]    cnt_wd;
	logic [STATUS_W-1:0] now_st;
	logic                now_ev;
	logic [SLOT_W-1:0]   now_es;
	logic [COUNT_W-1:0]  now_ec, cnt_sat;
	logic                out_load;

	assign top_eff = (32'(slot_top_q) > TOP_LIM) ? SLOT_W'(TOP_LIM) : slot_top_q;
	assign cur_nxt = (cur_q >= top_eff) ? '0 : cur_q + 1'b1;
	assign map_slot = map_rd_q[SLOT_AW-1:0];
	assign id_idx   = ID_AW'(id_q);
	assign clr_id   = ID_AW'(clr_q);
	assign clr_slot = SLOT_AW'(clr_q);
	assign clr_map_en = (32'(clr_q) < TIMER_IDS);
	assign clr_cnt_en = (32'(clr_q) < MAX_SLOTS);

	always_comb begin
		case (cmd.cnt_sel)
			CA_PREV: cnt_ra = SLOT_AW'(prev_q);
			CA_CUR:  cnt_ra = SLOT_AW'(cur_q);
			CA_MAP:  cnt_ra = map_slot;
			default: cnt_ra = SLOT_AW'(cur_nxt);
		endcase
	end

	// memory write ports: clear sweep or regular update
	always_comb begin
		map_we = cmd.clr ? clr_map_en : cmd.map_wr;
		map_wa = cmd.clr ? clr_id : id_idx;
		map_wd = '0;
		if (!cmd.clr && cmd.map_set) begin
			map_wd = {1'b1, cmd.map_cur ? SLOT_AW'(cur_q) : SLOT_AW'(prev_q)};
		end
		cnt_we = cmd.clr ? clr_cnt_en : (cmd.cnt_dec || cmd.cnt_inc);
		cnt_wa = cmd.clr ? clr_slot : cnt_wa_q;
		if (cmd.clr) begin
			cnt_wd = '0;
		end else if (cmd.cnt_inc) begin
			cnt_wd = cnt_rd_q + 1'b1;
		end else begin
			cnt_wd = cnt_rd_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (cmd.accept) begin
			map_rd_q <= map_mem[ID_AW'(timer_id)];
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cmd.cnt_rd) begin
			cnt_rd_q <= cnt_mem[cnt_ra];
			cnt_wa_q <= cnt_ra;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			id_q <= timer_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_top_q <= SLOT_TOP_RST;
			cur_q      <= '0;
			prev_q     <= SLOT_W'(PREV_RST);
			clr_q      <= '0;
		end else begin
			if (cfg_we) begin
				slot_top_q <= cfg_data;
			end
			if (cmd.adv) begin
				prev_q <= cur_q;
				cur_q  <= cur_nxt;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign cnt_sat = (32'(cnt_rd_q) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cnt_rd_q);

	always_comb begin
		now_st = cmd.res;
		now_ev = 1'b0;
		now_es = '0;
		now_ec = '0;
		if (cmd.tick_res) begin
			now_ev = (cnt_rd_q != '0);
			now_es = cur_q;
			now_ec = cnt_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			res_st_q <= now_st;
			res_ev_q <= now_ev;
			res_es_q <= now_es;
			res_ec_q <= now_ec;
		end
	end

	assign out_load = (cmd.fin || cmd.push) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status        <= cmd.push ? res_st_q : now_st;
			expired_valid <= cmd.push ? res_ev_q : now_ev;
			expired_slot  <= cmd.push ? res_es_q : now_es;
			expired_count <= cmd.push ? res_ec_q : now_ec;
		end
	end

	assign sts.clr_last = (clr_q == CLR_W'(CLR_N - 1));
	assign sts.out_free = !out_valid || !out_stall;
	assign sts.id_ok    = (32'(id_q) < TIMER_IDS);
	assign sts.hit      = map_rd_q[SLOT_AW];
	assign sts.in_prev  = (32'(map_slot) == 32'(prev_q));
	assign sts.in_cur   = (32'(map_slot) == 32'(cur_q));

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for idle_timeout_timing_wheel: directed table, then random phases over several
// wheel sizes, checked field by field against a behavioral model of the wheel or written-in responses.
// Depends on ttw_pkg and the idle_timeout_timing_wheel RTL.

module tb;
	import ttw_pkg::*;

	localparam int STUCK_LIMIT = 5000;  // covers the clearing pass and the long receiver hold
	localparam int N_PHASES    = 8;
	localparam int PHASE_REQS  = 75;
	localparam int POOL_SIZE   = 12;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		res_t               status;
		logic               ev;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] cnt;
	} wheel_resp_t;

	typedef struct {
		logic              is_cfg;
		act_t              act;
		logic [ID_W-1:0]   id;
		logic [SLOT_W-1:0] top;
		logic              typed;  // use the written-in response instead of the model
		wheel_resp_t       want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [SLOT_W-1:0]   cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [ACTION_W-1:0] action = '0;
	logic [ID_W-1:0]     timer_id = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                expired_valid;
	logic [SLOT_W-1:0]   expired_slot;
	logic [COUNT_W-1:0]  expired_count;

	// wheel model state
	logic              map_valid [1024];
	logic [SLOT_W-1:0] map_slot [1024];
	int                slot_cnt [64];
	logic [SLOT_W-1:0] cur_slot;
	logic [SLOT_W-1:0] prev_slot;
	logic [SLOT_W-1:0] top_reg;

	wheel_resp_t resp_q[$];
	int          errors = 0;
	int          stuck = 0;
	logic        quiet_tx = 1'b0;
	logic        quiet_rx = 1'b0;
	logic        rush = 1'b0;

	idle_timeout_timing_wheel dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.timer_id      (timer_id),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.expired_valid (expired_valid),
		.expired_slot  (expired_slot),
		.expired_count (expired_count)
	);

	always #10 clk = ~clk;

	function automatic wheel_resp_t wheel_step(act_t act, logic [ID_W-1:0] id);
		wheel_resp_t r;
		int          c;
		r.status = RES_DONE;
		r.ev     = 1'b0;
		r.slot   = '0;
		r.cnt    = '0;
		if (act == ACT_TICK) begin
			prev_slot = cur_slot;
			cur_slot  = (cur_slot >= top_reg) ? '0 : cur_slot + 1'b1;
			c = slot_cnt[cur_slot];
			if (c > COUNT_MAX)
				c = COUNT_MAX;
			r.slot = cur_slot;
			r.cnt  = COUNT_W'(c);
			r.ev   = (c != 0);
		end else if (act == ACT_INSERT) begin
			if (map_valid[id]) begin
				r.status = RES_DUP;
			end else begin
				map_valid[id] = 1'b1;
				map_slot[id]  = prev_slot;
				slot_cnt[prev_slot]++;
			end
		end else if (!map_valid[id]) begin
			r.status = RES_ABSENT;
		end else if (act == ACT_TOUCH) begin
			// an id sitting in the previous slot stays put
			if (map_slot[id] != prev_slot) begin
				slot_cnt[map_slot[id]]--;
				map_slot[id] = cur_slot;
				slot_cnt[cur_slot]++;
			end
		end else begin
			slot_cnt[map_slot[id]]--;
			map_valid[id] = 1'b0;
			map_slot[id]  = '0;
		end
		return r;
	endfunction

	function automatic stim_row_t stim_row(logic is_cfg, act_t act, int val, logic typed,
			res_t st, logic ev, int slot, int cnt);
		stim_row_t row;
		row.is_cfg      = is_cfg;
		row.act         = act;
		row.id          = ID_W'(val);
		row.top         = SLOT_W'(val);
		row.typed       = typed;
		row.want.status = st;
		row.want.ev     = ev;
		row.want.slot   = SLOT_W'(slot);
		row.want.cnt    = COUNT_W'(cnt);
		return row;
	endfunction

	task automatic report(string field, int got, int want);
		$display("tb: mismatch on %s: got %0d, want %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	task automatic send_req(act_t act, logic [ID_W-1:0] id, logic typed, wheel_resp_t want);
		int          gap;
		wheel_resp_t got;
		gap = (quiet_tx || rush) ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		timer_id <= id;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = wheel_step(act, id);
		resp_q.push_back(typed ? want : got);
	endtask

	// slot_top only changes with no request in flight
	task automatic write_top(logic [SLOT_W-1:0] val);
		in_valid <= 1'b0;
		while (resp_q.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		top_reg = val;
	endtask

	initial begin
		stim_row_t       rows[$];
		logic [ID_W-1:0] pool [POOL_SIZE];
		int              tops [N_PHASES];
		act_t            act;
		logic [ID_W-1:0] id;
		int              pick;
		wheel_resp_t     none;

		tops = '{63, 5, 1, 0, 63, 2, 40, 9};
		none = '0;
		for (int i = 0; i < 1024; i++) begin
			map_valid[i] = 1'b0;
			map_slot[i]  = '0;
		end
		for (int i = 0; i < 64; i++)
			slot_cnt[i] = 0;
		top_reg   = SLOT_TOP_RST;
		cur_slot  = '0;
		prev_slot = SLOT_TOP_RST;

		rows.push_back(stim_row(0, ACT_TICK,   0,    1, RES_DONE,   0, 1, 0));
		rows.push_back(stim_row(0, ACT_TOUCH,  5,    1, RES_ABSENT, 0, 0, 0));
		rows.push_back(stim_row(0, ACT_REMOVE, 1023, 1, RES_ABSENT, 0, 0, 0));
		rows.push_back(stim_row(0, ACT_INSERT, 0,    1, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_INSERT, 0,    1, RES_DUP,    0, 0, 0));
		rows.push_back(stim_row(0, ACT_INSERT, 1023, 1, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_TOUCH,  0,    0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_TICK,   0,    0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_TOUCH,  0,    0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_TOUCH,  0,    0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_INSERT, 512,  0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_REMOVE, 1023, 0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_REMOVE, 1023, 1, RES_ABSENT, 0, 0, 0));
		// lower the top below the current slot, then wrap
		rows.push_back(stim_row(1, ACT_TICK,   1,    0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_TICK,   0,    0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_TICK,   0,    0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_TICK,   0,    0, RES_DONE,   0, 0, 0));
		// one-slot wheel
		rows.push_back(stim_row(1, ACT_TICK,   0,    0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_INSERT, 341,  0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_INSERT, 682,  0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_TICK,   0,    0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_TOUCH,  341,  0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(1, ACT_TICK,   63,   0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_TICK,   0,    0, RES_DONE,   0, 0, 0));
		rows.push_back(stim_row(0, ACT_TICK,   0,    0, RES_DONE,   0, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				write_top(rows[i].top);
			else
				send_req(rows[i].act, rows[i].id, rows[i].typed, rows[i].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			write_top(SLOT_W'(tops[p]));
			quiet_tx = ($urandom_range(0, 3) == 0);
			quiet_rx = ($urandom_range(0, 3) == 0);
			// a small id pool per phase keeps inserts, touches and removes hitting
			for (int k = 0; k < POOL_SIZE; k++)
				pool[k] = ID_W'($urandom);
			for (int n = 0; n < PHASE_REQS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 30)
					act = ACT_INSERT;
				else if (pick < 60)
					act = ACT_TOUCH;
				else if (pick < 80)
					act = ACT_REMOVE;
				else
					act = ACT_TICK;
				if ($urandom_range(0, 9) == 0)
					id = ID_W'($urandom);
				else
					id = pool[$urandom_range(0, POOL_SIZE - 1)];
				send_req(act, id, 1'b0, none);
			end
		end
		in_valid <= 1'b0;

		while (resp_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		int          n;
		int          rcvd;
		wheel_resp_t want;
		rcvd = 0;
		forever begin
			n = quiet_rx ? 0 : $urandom_range(0, 16);
			// one long hold so the block backs up and stalls its input
			if (rcvd == HOLD_AT) begin
				n    = HOLD_CYCLES;
				rush = 1'b1;
			end
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rush = 1'b0;
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			rcvd++;
			if (resp_q.size() == 0) begin
				report("result with no request pending", 1, 0);
			end else begin
				want = resp_q.pop_front();
				if (status !== want.status)
					report("status", status, want.status);
				if (expired_valid !== want.ev)
					report("expired_valid", expired_valid, want.ev);
				if (expired_slot !== want.slot)
					report("expired_slot", expired_slot, want.slot);
				if (expired_count !== want.cnt)
					report("expired_count", expired_count, want.cnt);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck == STUCK_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

endmodule

>>> sim.f
design/ttw_pkg.sv
design/ttw_ctrl.sv
design/ttw_dp.sv
design/idle_timeout_timing_wheel.sv
tb/tb.sv
